[src/bpia_pkg.sv]
// bpia_pkg: shared types, constants and the arctangent table of the
// bus power injection accumulator; no dependencies
package bpia_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ROW_INDEX_BITS = 10;
  localparam int ATAN_ENTRIES   = 24;
  localparam int STAGE_BITS     = $clog2(ATAN_ENTRIES);
  // cordic datapath width, headroom over the q1.30 values
  localparam int CW             = 34;

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(32'sh26DD3B6A);

  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [ROW_INDEX_BITS-1:0] row_index;
    logic [15:0]               own_magnitude;
    logic [15:0]               own_angle;
    logic [15:0]               neighbour_magnitude;
    logic [15:0]               neighbour_angle;
    logic signed [31:0]        conductance;
    logic signed [31:0]        susceptance;
    logic                      last_term;
  } in_item_t;

  typedef struct packed {
    logic [ROW_INDEX_BITS-1:0] row_index_out;
    logic signed [39:0]        real_power;
    logic signed [39:0]        reactive_power;
    logic                      overflow;
  } out_item_t;

  // data handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      flip;
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [CW-1:0]      z;
    logic [15:0]               vi;
    logic [15:0]               vj;
    logic signed [31:0]        g;
    logic signed [31:0]        b;
    logic                      last;
    logic [ROW_INDEX_BITS-1:0] row;
  } cell_t;

endpackage

[src/bpia_if.sv]
// bpia_in_if / bpia_out_if: valid-ready channels for terms and results
// depends on bpia_pkg
interface bpia_in_if;
  logic               valid;
  logic               ready;
  bpia_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpia_out_if;
  logic                valid;
  logic                ready;
  bpia_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/bus_power_injection_accumulator.sv]
// bus_power_injection_accumulator: top level, angle fold, cordic cell row,
// product and accumulate stages; depends on bpia_pkg, bpia_if, cells and mac
//
// Usage: terms of one admittance row arrive on in_i, one transfer per term;
// the term with last_term set closes the row and one result with P, Q and
// the overflow flag leaves on out_o. Non-final terms give no result.
// Throughput: one term per cycle unless out_o stalls. The row of CORDIC_STAGES
// cordic cells, three product/accumulate stages and the output register form
// one pipeline that advances as a whole.
// Path: the last term of a row passes each cordic cell register, the three
// product/accumulate stages and the output register, which drives out_o.valid.
// Stall: the result sits in the output register; while it is not taken the
// whole pipeline freezes and in_i.ready is low, so nothing is lost.
// Reset: rst_ni clears all valid bits, both row sums and the overflow flag;
// the block takes terms in the first cycle after reset.
module bus_power_injection_accumulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpia_in_if.sink       in_i,
  bpia_out_if.source    out_o
);
  import bpia_pkg::*;

  logic                en;
  logic                out_valid_q;
  out_item_t           out_data_q;
  logic [15:0]         d, df;
  logic                flip;
  cell_t               head;
  cell_t               chain [CORDIC_STAGES+1];
  logic                res_valid;
  out_item_t           res;

  // pipeline moves when the output register is free or being taken
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // angle difference folded into the right half plane
  always_comb begin
    d          = in_i.data.own_angle - in_i.data.neighbour_angle;
    flip       = d[15] ^ d[14];
    df         = flip ? (d ^ 16'h8000) : d;
    head.valid = in_i.valid;
    head.flip  = flip;
    head.x     = GAIN_Q30;
    head.y     = '0;
    head.z     = {{(CW-32){df[15]}}, df, 16'h0000};
    head.vi    = in_i.data.own_magnitude;
    head.vj    = in_i.data.neighbour_magnitude;
    head.g     = in_i.data.conductance;
    head.b     = in_i.data.susceptance;
    head.last  = in_i.data.last_term;
    head.row   = in_i.data.row_index;
  end

  assign chain[0] = head;

  // row of cordic cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    bpia_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (STAGE_BITS'(i)),
      .cell_i  (chain[i]),
      .cell_o  (chain[i+1])
    );
  end

  bpia_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cell_i      (chain[CORDIC_STAGES]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
endmodule

[src/bpia_cordic_cell.sv]
// bpia_cordic_cell: one rotation-mode cordic iteration, registered
// depends on bpia_pkg
module bpia_cordic_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [bpia_pkg::STAGE_BITS-1:0]   stage_i,
  input  bpia_pkg::cell_t                   cell_i,
  output bpia_pkg::cell_t                   cell_o
);
  import bpia_pkg::*;

  cell_t                cell_d, cell_q;
  logic signed [CW-1:0] xs, ys, at;

  // shift-add micro rotation
  always_comb begin
    xs     = cell_i.x >>> stage_i;
    ys     = cell_i.y >>> stage_i;
    at     = signed'(CW'(ATAN_TAB[stage_i]));
    cell_d = cell_i;
    if (!cell_i.z[CW-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

[src/bpia_mac.sv]
// bpia_mac: admittance products, voltage scaling and saturating row sums
// depends on bpia_pkg
module bpia_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bpia_pkg::cell_t     cell_i,
  output logic                res_valid_o,
  output bpia_pkg::out_item_t res_o
);
  import bpia_pkg::*;

  localparam int PW = 32 + CW;

  // stage 1: sign fold and four products
  logic signed [CW-1:0] c, s;
  logic signed [PW-1:0] gc_q, bs_q, gs_q, bc_q;
  logic [17:0]          vv1_q;
  logic [31:0]          vprod;
  logic                 v1_q, l1_q;
  logic [ROW_INDEX_BITS-1:0] r1_q;

  assign c     = cell_i.flip ? -cell_i.x : cell_i.x;
  assign s     = cell_i.flip ? -cell_i.y : cell_i.y;
  assign vprod = 32'(cell_i.vi) * 32'(cell_i.vj);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q  <= cell_i.valid;
      l1_q  <= cell_i.last;
      r1_q  <= cell_i.row;
      gc_q  <= PW'(cell_i.g) * PW'(c);
      bs_q  <= PW'(cell_i.b) * PW'(s);
      gs_q  <= PW'(cell_i.g) * PW'(s);
      bc_q  <= PW'(cell_i.b) * PW'(c);
      vv1_q <= vprod[31:14];
    end
  end

  // stage 2: combine and drop the q1.30 scale
  localparam int TW = PW + 1 - 30;
  logic signed [PW:0]   sp, sq;
  logic signed [TW-1:0] tp_q, tq_q;
  logic [17:0]          vv2_q;
  logic                 v2_q, l2_q;
  logic [ROW_INDEX_BITS-1:0] r2_q;

  assign sp = (PW+1)'(gc_q) + (PW+1)'(bs_q);
  assign sq = (PW+1)'(gs_q) - (PW+1)'(bc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q  <= v1_q;
      l2_q  <= l1_q;
      r2_q  <= r1_q;
      tp_q  <= sp[PW:30];
      tq_q  <= sq[PW:30];
      vv2_q <= vv1_q;
    end
  end

  // stage 3: scale by vi*vj
  localparam int MW = TW + 19;
  localparam int KW = MW - 14;
  logic signed [MW-1:0] mp, mq;
  logic signed [18:0]   vvs;
  logic signed [KW-1:0] kp_q, kq_q;
  logic                 v3_q, l3_q;
  logic [ROW_INDEX_BITS-1:0] r3_q;

  assign vvs = signed'({1'b0, vv2_q});
  assign mp  = MW'(tp_q) * MW'(vvs);
  assign mq  = MW'(tq_q) * MW'(vvs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
      l3_q <= l2_q;
      r3_q <= r2_q;
      kp_q <= mp[MW-1:14];
      kq_q <= mq[MW-1:14];
    end
  end

  // stage 4: saturating accumulate and output clamp
  logic signed [63:0] psum_q, qsum_q, pn, qn;
  logic               flag_q;
  logic signed [64:0] pa, qa;
  logic               satp, satq, clp, clq;
  localparam logic signed [39:0] OUT_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] OUT_MIN = {1'b1, {39{1'b0}}};

  always_comb begin
    pa   = 65'(psum_q) + 65'(kp_q);
    qa   = 65'(qsum_q) + 65'(kq_q);
    satp = pa[64] != pa[63];
    satq = qa[64] != qa[63];
    pn   = satp ? (pa[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}}) : pa[63:0];
    qn   = satq ? (qa[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}}) : qa[63:0];
    clp  = !((&pn[63:39]) || !(|pn[63:39]));
    clq  = !((&qn[63:39]) || !(|qn[63:39]));
    res_o.row_index_out  = r3_q;
    res_o.real_power     = clp ? (pn[63] ? OUT_MIN : OUT_MAX) : pn[39:0];
    res_o.reactive_power = clq ? (qn[63] ? OUT_MIN : OUT_MAX) : qn[39:0];
    res_o.overflow       = flag_q | satp | satq | clp | clq;
    res_valid_o          = v3_q & l3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
      qsum_q <= '0;
      flag_q <= 1'b0;
    end else if (en_i && v3_q) begin
      if (l3_q) begin
        psum_q <= '0;
        qsum_q <= '0;
        flag_q <= 1'b0;
      end else begin
        psum_q <= pn;
        qsum_q <= qn;
        flag_q <= flag_q | satp | satq;
      end
    end
  end
endmodule

[bench/bpia_scoreboard.sv]
// bpia_scoreboard: predicts row injections of the bus power injection accumulator
// and checks the results; depends on bpia_pkg
package bpia_scoreboard_pkg;
  import bpia_pkg::*;

  class row_power_scoreboard;
    longint              p_acc;
    longint              q_acc;
    bit                  sat_seen;
    out_item_t           pending_rows[$];
    int unsigned         mismatches;
    int unsigned         rows_checked;
    int unsigned         sat_rows;

    function new();
      p_acc = 0;
      q_acc = 0;
      sat_seen = 0;
      mismatches = 0;
      rows_checked = 0;
      sat_rows = 0;
    endfunction

    // saturating 64-bit add
    function longint add_sat(longint a, longint b);
      longint r;
      r = a + b;
      if (b > 0 && r < a) begin
        sat_seen = 1;
        return 64'sh7FFFFFFFFFFFFFFF;
      end
      if (b < 0 && r > a) begin
        sat_seen = 1;
        return 64'sh8000000000000000;
      end
      return r;
    endfunction

    // rotation-mode cordic on the folded angle difference
    static function void trig(logic [15:0] d16, output longint c, output longint s);
      logic    flip;
      longint  x, y, z, xs, ys;
      flip = d16[15] ^ d16[14];
      if (flip) d16 = d16 ^ 16'h8000;
      z = longint'($signed(d16)) * 65536;
      x = longint'(GAIN_Q30);
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
        end else begin
          x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    static function longint clamp40(longint v, ref bit hit);
      if (v > 64'sd549755813887) begin
        hit = 1;
        return 64'sd549755813887;
      end
      if (v < -64'sd549755813888) begin
        hit = 1;
        return -64'sd549755813888;
      end
      return v;
    endfunction

    // note an accepted term
    function void note_term(in_item_t t);
      longint    c, s, tp, tq, vv;
      bit        hit;
      out_item_t r;
      trig(t.own_angle - t.neighbour_angle, c, s);
      tp = (longint'(t.conductance) * c + longint'(t.susceptance) * s) >>> 30;
      tq = (longint'(t.conductance) * s - longint'(t.susceptance) * c) >>> 30;
      vv = longint'((64'(t.own_magnitude) * 64'(t.neighbour_magnitude)) >> 14);
      p_acc = add_sat(p_acc, (tp * vv) >>> 14);
      q_acc = add_sat(q_acc, (tq * vv) >>> 14);
      if (!t.last_term) return;
      hit = sat_seen;
      r.row_index_out  = t.row_index;
      r.real_power     = 40'(clamp40(p_acc, hit));
      r.reactive_power = 40'(clamp40(q_acc, hit));
      r.overflow       = hit;
      if (hit) sat_rows++;
      pending_rows.push_back(r);
      p_acc = 0;
      q_acc = 0;
      sat_seen = 0;
    endfunction

    // check one result transfer
    function void check_row(out_item_t got);
      out_item_t want;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d P %0d Q %0d", got.row_index_out,
                   got.real_power, got.reactive_power);
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp row %0d P %0d Q %0d ovf %0b, got row %0d P %0d Q %0d ovf %0b",
                   want.row_index_out, want.real_power, want.reactive_power,
                   want.overflow, got.row_index_out, got.real_power,
                   got.reactive_power, got.overflow);
      end
    endfunction
  endclass
endpackage

[bench/bus_power_injection_accumulator_tb.sv]
// bus_power_injection_accumulator_tb: streams admittance rows with random gaps
// and stalls; depends on bpia_pkg, bpia_if, bpia_scoreboard and the rtl
module bus_power_injection_accumulator_tb;
  import bpia_pkg::*;
  import bpia_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i = 0;
  logic rst_ni = 0;

  bpia_in_if  in_ch ();
  bpia_out_if out_ch ();

  bus_power_injection_accumulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  row_power_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned idle_cycles;
  int unsigned terms_sent;
  bit          timed_out;

  initial begin
    sb = new();
    in_ch.valid  = 0;
    in_ch.data   = '0;
    out_ch.ready = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    idle_cycles  = 0;
    terms_sent   = 0;
    timed_out    = 0;
  end

  // sampling at the rising edge: scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_term(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_row(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out <= 1;
        $display("watchdog expired, %0d rows outstanding", sb.pending_rows.size());
        $display("FAIL bus_power_injection_accumulator");
        $finish;
      end
    end
  end

  // receiver stalls at the falling edge
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // one term transfer, with random gap before it; valid stays high between
  // back to back transfers
  task automatic send_term(in_item_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.data  <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    terms_sent++;
  endtask

  function automatic in_item_t rand_term(bit last, logic [9:0] row);
    in_item_t t;
    t.row_index           = row;
    t.own_magnitude       = $urandom_range(99) < 80 ? 16'($urandom_range(12000, 20000))
                                                     : 16'($urandom);
    t.neighbour_magnitude = $urandom_range(99) < 80 ? 16'($urandom_range(12000, 20000))
                                                     : 16'($urandom);
    t.own_angle           = 16'($urandom);
    t.neighbour_angle     = $urandom_range(1) ? t.own_angle + 16'($urandom_range(4000))
                                              : 16'($urandom);
    case ($urandom_range(3))
      0: begin
        t.conductance = $signed($urandom);
        t.susceptance = $signed($urandom);
      end
      default: begin
        t.conductance = 32'($signed($urandom_range(4000000)) - 2000000);
        t.susceptance = 32'($signed($urandom_range(4000000)) - 2000000);
      end
    endcase
    t.last_term = last;
    return t;
  endfunction

  // a well formed row of random length
  task automatic send_row(int n);
    logic [9:0] row;
    row = 10'($urandom);
    for (int i = 0; i < n; i++) send_term(rand_term(i == n - 1, row));
  endtask

  // directed extremes: zeros, full scale, angle wrap, big sums that clamp
  task automatic directed_part();
    in_item_t     t;
    logic [159:0] raw;
    t = '0; t.last_term = 1;
    send_term(t);
    t = '1; t.conductance = 32'sh7FFFFFFF; t.susceptance = 32'sh80000000;
    send_term(t);
    t.conductance = 32'sh80000000; t.susceptance = 32'sh7FFFFFFF;
    t.row_index = '0; send_term(t);
    foreach (ATAN_TAB[k]) begin
      if (k >= 8) break;
      t = '0;
      t.row_index = 10'(k);
      t.own_magnitude = 16'hFFFF; t.neighbour_magnitude = 16'hFFFF;
      t.own_angle = 16'(k * 16'h2000); t.neighbour_angle = 16'hFFFF - 16'(k);
      t.conductance = 32'sh7FFFFFFF; t.susceptance = 32'sh7FFFFFFF;
      t.last_term = (k == 7);
      send_term(t);
    end
    // angles at the quarter-turn fold boundaries
    for (int k = 0; k < 4; k++) begin
      t = '0;
      t.own_magnitude = 16'h4000; t.neighbour_magnitude = 16'h4000;
      t.own_angle = (k < 2) ? 16'h4000 : 16'hC000;
      t.neighbour_angle = 16'(k & 1);
      t.conductance = 32'sh00010000; t.susceptance = -32'sh00010000;
      t.last_term = 1;
      send_term(t);
    end
    // mid-row noise: random fields, random last flags
    for (int k = 0; k < 6; k++) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(in_item_t)-1:0];
      send_term(t);
    end
    t = '0; t.last_term = 1; send_term(t);
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned start;
    start = terms_sent;
    while (terms_sent - start < items) begin
      if ($urandom_range(9) == 0)
        send_term(rand_term($urandom_range(1), 10'($urandom)));
      else
        send_row($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    directed_part();
    src_idle_pct = 36; snk_idle_pct = 54;
    random_phase(310);
    src_idle_pct = 54; snk_idle_pct = 36;
    random_phase(310);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_phase(310);
    // close any open row so every result is seen
    send_term(rand_term(1, 10'd0));
    in_ch.valid <= 0;
    while (sb.pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d terms, checked %0d rows, %0d rows with overflow",
             terms_sent, sb.rows_checked, sb.sat_rows);
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0)
      $display("PASS bus_power_injection_accumulator");
    else
      $display("FAIL bus_power_injection_accumulator");
    $finish;
  end
endmodule
